// ----- design/iph_pkg.sv -----
`default_nettype none

package iph_pkg;

   localparam logic [19:0] BIG_MOD   = 20'd999983;
   localparam logic [19:0] MID_MOD   = 20'd7393;
   localparam logic [19:0] BIG_RECIP = 20'd2147;
   localparam logic [19:0] MID_RECIP = 20'd141;
   localparam logic [19:0] PRE_MUL   = 20'd617;
   localparam logic [19:0] PRE_ADD   = 20'h02342;
   localparam logic [19:0] XOR_A     = 20'h55555;
   localparam logic [19:0] XOR_B     = 20'ha57c2;
   localparam logic [19:0] XOR_C     = 20'h20093;
   localparam logic [19:0] LOW_LIMIT = 20'd100;

   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_PRE  = 3'd1;
   localparam logic [2:0] OP_QUO  = 3'd2;
   localparam logic [2:0] OP_PRD  = 3'd3;
   localparam logic [2:0] OP_SCL  = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic       mid;
   } ctrl_type;

endpackage

`default_nettype wire

// ----- design/iterated_prime_mixing_hash.sv -----
// Rounds: 1 to 8, set by req_code_in[2:0]; a round that ends below 100 takes an extra
// scaling step; rsp_valid pulses when the last round of the start transaction ends.
// Throughput: one transaction at a time, set by the single shared multiplier;
// busy falls in the cycle rsp_valid pulses, so a new start is taken in that cycle.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (synchronous, active high) returns to idle and drops rsp_valid.
`default_nettype none

module iterated_prime_mixing_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [19:0] req_code_in,
   output logic             rsp_valid,
   output logic      [19:0] rsp_hash_out
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRE   = 3'd1;
   localparam logic [2:0] ST_QUO   = 3'd2;
   localparam logic [2:0] ST_PRD   = 3'd3;
   localparam logic [2:0] ST_SUB   = 3'd4;
   localparam logic [2:0] ST_SCL   = 3'd5;
   localparam logic [2:0] ST_SMALL = 3'd6;

   localparam logic [1:0] PH_FIRST = 2'd0;
   localparam logic [1:0] PH_MID   = 2'd1;
   localparam logic [1:0] PH_LAST  = 2'd2;

   localparam logic [1:0] MIX_XOR  = 2'd0;
   localparam logic [1:0] MIX_OR   = 2'd1;
   localparam logic [1:0] MIX_MASK = 2'd2;

   function automatic logic [1:0] mix_code(input logic [2:0] t);
      logic [1:0] code;
      case (t)
         3'd0:    code = MIX_MASK;
         3'd3:    code = MIX_OR;
         3'd6:    code = MIX_OR;
         default: code = MIX_XOR;
      endcase
      return code;
   endfunction

   logic [2:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic        mid_ff, mid_in;
   logic [2:0]  round_ff, round_in;
   logic [2:0]  last_ff, last_in;
   logic [19:0] v_ff, v_in;
   logic [30:0] x_ff, x_in;
   logic [10:0] q_ff, q_in;
   logic [30:0] p_ff, p_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [19:0] rsp_hash_ff, rsp_hash_in;

   iph_pkg::ctrl_type ctrl;
   logic [50:0]       product;
   logic [19:0]       residue;
   logic [19:0]       mixed;
   logic              finish;
   logic [19:0]       fin_value;

   iph_alu u_alu (
      .ctrl    (ctrl),
      .v       (v_ff),
      .x       (x_ff),
      .q       (q_ff),
      .p       (p_ff),
      .product (product),
      .residue (residue)
   );

   always_comb begin
      ctrl.mid = mid_ff;
      case (state_ff)
         ST_PRE:   ctrl.op = iph_pkg::OP_PRE;
         ST_QUO:   ctrl.op = iph_pkg::OP_QUO;
         ST_PRD:   ctrl.op = iph_pkg::OP_PRD;
         ST_SCL:   ctrl.op = iph_pkg::OP_SCL;
         ST_SMALL: ctrl.op = iph_pkg::OP_SCL;
         default:  ctrl.op = iph_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      case (mix_code(round_ff))
         MIX_XOR: mixed = residue ^ iph_pkg::XOR_B;
         MIX_OR:  mixed = residue | iph_pkg::MID_MOD;
         default: mixed = residue ^ (iph_pkg::XOR_B & residue & iph_pkg::MID_MOD);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      mid_in       = mid_ff;
      round_in     = round_ff;
      last_in      = last_ff;
      v_in         = v_ff;
      x_in         = x_ff;
      q_in         = q_ff;
      p_in         = p_ff;
      rsp_valid_in = 1'b0;
      rsp_hash_in  = rsp_hash_ff;
      finish       = 1'b0;
      fin_value    = residue;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               v_in     = req_code_in;
               round_in = '0;
               last_in  = req_code_in[2:0];
               state_in = ST_PRE;
            end
         end
         ST_PRE: begin
            x_in     = product[30:0];
            mid_in   = 1'b0;
            phase_in = PH_FIRST;
            state_in = ST_QUO;
         end
         ST_QUO: begin
            q_in     = mid_ff ? product[30:20] : product[41:31];
            state_in = ST_PRD;
         end
         ST_PRD: begin
            p_in     = product[30:0];
            state_in = ST_SUB;
         end
         ST_SUB: begin
            case (phase_ff)
               PH_FIRST: begin
                  x_in     = {11'b0, mixed};
                  mid_in   = 1'b1;
                  phase_in = PH_MID;
                  state_in = ST_QUO;
               end
               PH_MID: begin
                  v_in     = residue ^ iph_pkg::XOR_C;
                  state_in = ST_SCL;
               end
               PH_LAST: begin
                  v_in = residue;
                  if (residue < iph_pkg::LOW_LIMIT) begin
                     state_in = ST_SMALL;
                  end else begin
                     finish = 1'b1;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCL: begin
            x_in     = product[30:0];
            mid_in   = 1'b0;
            phase_in = PH_LAST;
            state_in = ST_QUO;
         end
         ST_SMALL: begin
            finish    = 1'b1;
            fin_value = product[19:0];
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         if (round_ff == last_ff) begin
            rsp_valid_in = 1'b1;
            rsp_hash_in  = fin_value;
            state_in     = ST_IDLE;
         end else begin
            round_in = round_ff + 3'd1;
            v_in     = fin_value;
            state_in = ST_PRE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FIRST;
         mid_ff       <= 1'b0;
         round_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         mid_ff       <= mid_in;
         round_ff     <= round_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      x_ff        <= x_in;
      q_ff        <= q_in;
      p_ff        <= p_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hash_out = rsp_hash_ff;

endmodule

`default_nettype wire

// ----- design/iph_alu.sv -----
`default_nettype none

module iph_alu (
   input  wire iph_pkg::ctrl_type ctrl,
   input  wire logic [19:0]       v,
   input  wire logic [30:0]       x,
   input  wire logic [10:0]       q,
   input  wire logic [30:0]       p,
   output logic      [50:0]       product,
   output logic      [19:0]       residue
);

   logic [30:0] mul_a;
   logic [19:0] mul_b;
   logic [19:0] addend;
   logic [30:0] diff;
   logic [20:0] estimate;
   logic [19:0] modulus;

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      addend = '0;
      case (ctrl.op)
         iph_pkg::OP_PRE: begin
            mul_a  = {11'b0, v ^ iph_pkg::XOR_A};
            mul_b  = iph_pkg::PRE_MUL;
            addend = iph_pkg::PRE_ADD;
         end
         iph_pkg::OP_QUO: begin
            mul_a = x;
            mul_b = ctrl.mid ? iph_pkg::MID_RECIP : iph_pkg::BIG_RECIP;
         end
         iph_pkg::OP_PRD: begin
            mul_a = {20'b0, q};
            mul_b = ctrl.mid ? iph_pkg::MID_MOD : iph_pkg::BIG_MOD;
         end
         iph_pkg::OP_SCL: begin
            mul_a = {11'b0, v};
            mul_b = iph_pkg::MID_MOD;
         end
         default: begin
            mul_a  = '0;
            mul_b  = '0;
            addend = '0;
         end
      endcase
      product = {20'b0, mul_a} * {31'b0, mul_b} + {31'b0, addend};
   end

   // correct the residue left by the quotient estimate, which is short by at most one
   always_comb begin
      modulus  = ctrl.mid ? iph_pkg::MID_MOD : iph_pkg::BIG_MOD;
      diff     = x - p;
      estimate = diff[20:0];
      if (estimate >= {1'b0, modulus}) begin
         residue = 20'(estimate - {1'b0, modulus});
      end else begin
         residue = estimate[19:0];
      end
   end

endmodule

`default_nettype wire

// ----- design/iph_check.sv -----
`default_nettype none

module iph_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [19:0] rsp_hash_out
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after start transaction");

   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held longer than one cycle");

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result outside end of transaction");

   a_hash_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hash_out < 20'd999983)
      else $error("rsp_hash_out out of range");

endmodule

bind iterated_prime_mixing_hash iph_check u_iph_check (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_hash_out (rsp_hash_out)
);

`default_nettype wire
